[rtl/core/ess_pkg.sv]
// Shared types and constants of the excitation sample sequencer.
// Used by ess_core and excitation_sample_sequencer_top; depends on nothing.
`timescale 1ns / 1ps

package ess_pkg;

  localparam int unsigned AdcW    = 12;
  localparam int unsigned RegW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SmpIdxW = 10;

  // Trim subtracted from the phase when computing the remaining wait
  localparam logic [18:0] PhaseTrim = 19'd50;

  localparam logic [RegW-1:0] StartDelayRst = 16'd2500;
  localparam logic [RegW-1:0] SampleDelayRst = 16'd200;
  localparam logic [RegW-1:0] SampleGapRst = 16'd25;
  localparam logic [RegW-1:0] PhaseLenRst = 16'd1000;
  localparam logic [RegW-1:0] CycleLimitRst = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartDelay  = 3'd0,
    CfgSampleDelay = 3'd1,
    CfgSampleGap   = 3'd2,
    CfgPhaseLen    = 3'd3,
    CfgCycleLimit  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StepToggle  = 2'd0,
    StepSample1 = 2'd1,
    StepSample2 = 2'd2,
    StepSample3 = 2'd3
  } step_e;

  typedef enum logic {
    OpTick  = 1'b0,
    OpStart = 1'b1
  } op_e;

  typedef struct packed {
    logic            op;
    logic [AdcW-1:0] adc_first;
    logic [AdcW-1:0] adc_second;
  } item_t;

  typedef struct packed {
    logic               excitation_level;
    logic               sample_valid;
    logic [AdcW-1:0]    sample_value;
    logic               phase_tag;
    logic [SmpIdxW-1:0] sample_index;
    logic               buffer_overflow;
    logic               acquisition_done;
  } res_t;

endpackage

[rtl/core/ess_core.sv]
// Sequencer core: configuration registers, schedule state and the per-item step.
// Depends on ess_pkg.
`timescale 1ns / 1ps

module ess_core #(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ess_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ess_pkg::RegW-1:0]      cfg_data_i,
  input  logic                          step_i,
  input  ess_pkg::item_t                item_i,
  output ess_pkg::res_t                 res_o
);
  import ess_pkg::*;

  localparam int unsigned IdxW = $clog2(BUF_DEPTH + 1);
  localparam logic [IdxW-1:0] DepthVal = IdxW'(BUF_DEPTH);

  logic [RegW-1:0] start_delay_q, sample_delay_q, sample_gap_q, phase_len_q, cycle_limit_q;

  step_e           step_q, step_d;
  logic            drive_q, drive_d;
  logic [RegW-1:0] ticks_q, ticks_d;
  logic [RegW-1:0] cycles_q, cycles_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic            running_q, running_d;

  logic            alarm_w;
  logic            sample_w;
  logic            full_w;
  logic [18:0]     rest_diff_w;
  logic [RegW-1:0] rest_w;
  logic [AdcW:0]   sum_w;
  logic [IdxW+SmpIdxW-1:0] widx_ext_w;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q  <= StartDelayRst;
      sample_delay_q <= SampleDelayRst;
      sample_gap_q   <= SampleGapRst;
      phase_len_q    <= PhaseLenRst;
      cycle_limit_q  <= CycleLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStartDelay:  start_delay_q  <= cfg_data_i;
        CfgSampleDelay: sample_delay_q <= cfg_data_i;
        CfgSampleGap:   sample_gap_q   <= cfg_data_i;
        CfgPhaseLen:    phase_len_q    <= cfg_data_i;
        CfgCycleLimit:  cycle_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Remaining wait of a phase, clamped to at least one tick
  assign rest_diff_w = {3'b000, phase_len_q} - {3'b000, sample_delay_q}
                     - {2'b00, sample_gap_q, 1'b0} - PhaseTrim;
  assign rest_w = (rest_diff_w[18] || (rest_diff_w[17:0] == 18'd0)) ?
                  RegW'(1) : rest_diff_w[RegW-1:0];

  assign alarm_w  = (item_i.op == OpTick) && running_q && (ticks_q <= RegW'(1));
  assign sample_w = alarm_w && (step_q != StepToggle);
  assign full_w   = (widx_q >= DepthVal);
  assign sum_w    = {1'b0, item_i.adc_first} + {1'b0, item_i.adc_second};
  assign widx_ext_w = {{SmpIdxW{1'b0}}, widx_q};

  // Next state
  always_comb begin
    step_d    = step_q;
    drive_d   = drive_q;
    ticks_d   = ticks_q;
    cycles_d  = cycles_q;
    widx_d    = widx_q;
    running_d = running_q;
    if (step_i) begin
      if (item_i.op == OpStart) begin
        step_d    = StepToggle;
        drive_d   = 1'b0;
        ticks_d   = start_delay_q;
        cycles_d  = '0;
        widx_d    = '0;
        running_d = 1'b1;
      end else if (running_q) begin
        if (!alarm_w) begin
          ticks_d = ticks_q - RegW'(1);
        end else begin
          case (step_q)
            StepToggle: begin
              drive_d = ~drive_q;
              ticks_d = sample_delay_q;
              step_d  = StepSample1;
            end
            StepSample1: begin
              ticks_d = sample_gap_q;
              step_d  = StepSample2;
            end
            StepSample2: begin
              ticks_d = sample_gap_q;
              step_d  = StepSample3;
            end
            StepSample3: begin
              ticks_d = rest_w;
              step_d  = StepToggle;
              // An off phase just finished: count one full cycle, saturating
              if (!drive_q && (cycles_q != '1)) begin
                cycles_d = cycles_q + RegW'(1);
              end
            end
            default: step_d = StepToggle;
          endcase
          if (sample_w && !full_w) begin
            widx_d = widx_q + IdxW'(1);
          end
          if (cycles_d >= cycle_limit_q) begin
            running_d = 1'b0;
          end
        end
      end
    end
  end

  // Result of the item
  always_comb begin
    res_o = '0;
    res_o.excitation_level = drive_d;
    res_o.acquisition_done = alarm_w && (cycles_d >= cycle_limit_q);
    if (sample_w) begin
      res_o.sample_valid    = 1'b1;
      res_o.sample_value    = sum_w[AdcW:1];
      res_o.phase_tag       = drive_q;
      res_o.buffer_overflow = full_w;
      res_o.sample_index    = full_w ? '0 : widx_ext_w[SmpIdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StepToggle;
      drive_q   <= 1'b0;
      ticks_q   <= '0;
      cycles_q  <= '0;
      widx_q    <= '0;
      running_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      drive_q   <= drive_d;
      ticks_q   <= ticks_d;
      cycles_q  <= cycles_d;
      widx_q    <= widx_d;
      running_q <= running_d;
    end
  end

`ifndef SYNTH
  a_sample_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.sample_valid) |-> (running_q && (item_i.op == OpTick)))
    else $error("sample produced while not running");

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.acquisition_done) |=> !running_q)
    else $error("block still running after done");

  a_ovf_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.buffer_overflow |-> (res_o.sample_valid && (res_o.sample_index == '0)))
    else $error("overflow without sample or with nonzero index");

  a_widx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= DepthVal)
    else $error("write index past buffer depth");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (item_i.op == OpStart)) |=> (running_q && (widx_q == '0) && !drive_q))
    else $error("start did not arm the sequencer");
`endif

endmodule

[rtl/core/excitation_sample_sequencer_top.sv]
// Top level of the excitation sample sequencer: input and result registers
// around the sequencer core. Depends on ess_pkg and ess_core.
`timescale 1ns / 1ps

// Excitation sample sequencer. Each input item is a timer tick carrying two
// 12-bit converter readings (op = 0) or a start command (op = 1). After a
// start the block waits start_delay ticks, then toggles the excitation drive
// (first toggle turns it on), takes three samples sample_delay and then
// inter_sample_gap ticks later, and waits the rest of the phase before the
// next toggle; it stops and pulses acquisition_done after cycle_limit full
// on/off cycles. Every item yields exactly one result item. Throughput is one
// item per clock cycle while the result side is not stalled. An accepted item
// is held in the input register, and its result is captured in the result
// register when the item advances through the core. The whole schedule
// update of an item is done combinationally by the core's step logic, which
// is what sets that rate. Both sides may stall freely: the input register and
// the result register decouple them, and a new item is taken whenever the
// result register is free or being drained. Configuration writes are always
// accepted and must only be issued while no item is in flight. There is no
// memory and no post-reset clearing pass.
module excitation_sample_sequencer_top #(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ess_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ess_pkg::RegW-1:0]      cfg_data_i,
  // Input item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [ess_pkg::AdcW-1:0]      adc_first_i,
  input  logic [ess_pkg::AdcW-1:0]      adc_second_i,
  // Result item channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          excitation_level_o,
  output logic                          sample_valid_o,
  output logic [ess_pkg::AdcW-1:0]      sample_value_o,
  output logic                          phase_tag_o,
  output logic [ess_pkg::SmpIdxW-1:0]   sample_index_o,
  output logic                          buffer_overflow_o,
  output logic                          acquisition_done_o
);
  import ess_pkg::*;

  logic  in_vld_q, in_vld_d;
  item_t in_item_q;
  logic  out_vld_q, out_vld_d;
  res_t  out_res_q;
  res_t  core_res;
  logic  advance;

  // Config registers take a write on any cycle
  assign cfg_ready_o = 1'b1;

  // Move the held item through the core when the result register is free
  // or is being drained in this same cycle
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the item on acceptance; hold it otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q.op         <= op_i;
      in_item_q.adc_first  <= adc_first_i;
      in_item_q.adc_second <= adc_second_i;
    end
  end

  ess_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (advance),
    .item_i      (in_item_q),
    .res_o       (core_res)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign excitation_level_o = out_res_q.excitation_level;
  assign sample_valid_o     = out_res_q.sample_valid;
  assign sample_value_o     = out_res_q.sample_value;
  assign phase_tag_o        = out_res_q.phase_tag;
  assign sample_index_o     = out_res_q.sample_index;
  assign buffer_overflow_o  = out_res_q.buffer_overflow;
  assign acquisition_done_o = out_res_q.acquisition_done;

endmodule
